// File: hdl/dpcs_pkg.sv
// Shared types and constants for the drive profile controlword sequencer.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package dpcs_pkg;

   // Reset value of the homing mode register
   localparam logic signed [7:0] HOMING_MODE_RESET = 8'sd6;

   // Command codes
   localparam logic [1:0] OP_POWER   = 2'd0;
   localparam logic [1:0] OP_HOMING  = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;
   localparam logic [1:0] OP_SWITCH  = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_BUSY  = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   // Decoded drive states
   localparam logic [3:0] DS_NOT_READY = 4'd0;
   localparam logic [3:0] DS_SO_DIS    = 4'd1;
   localparam logic [3:0] DS_READY     = 4'd2;
   localparam logic [3:0] DS_SWITCHED  = 4'd3;
   localparam logic [3:0] DS_OP_EN     = 4'd4;
   localparam logic [3:0] DS_QSTOP     = 4'd5;
   localparam logic [3:0] DS_FR_ACTIVE = 4'd6;
   localparam logic [3:0] DS_FAULT     = 4'd7;
   localparam logic [3:0] DS_UNKNOWN   = 4'd8;

   // Decoded homing states
   localparam logic [2:0] HS_IN_PROGRESS = 3'd0;
   localparam logic [2:0] HS_INTERRUPTED = 3'd1;
   localparam logic [2:0] HS_NO_TARGET   = 3'd2;
   localparam logic [2:0] HS_FINISHED    = 3'd3;
   localparam logic [2:0] HS_ERR_VEL     = 3'd4;
   localparam logic [2:0] HS_ERROR       = 3'd5;
   localparam logic [2:0] HS_UNKNOWN     = 3'd6;

   // Statusword masks
   localparam logic [15:0] SW_MASK_6F   = 16'h006F;
   localparam logic [15:0] SW_MASK_4F   = 16'h004F;
   localparam logic [15:0] HOMING_MASK  = 16'h3400;

   // Controlword values
   localparam logic [15:0] CW_ZERO        = 16'h0000;
   localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
   localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
   localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
   localparam logic [15:0] CW_DISABLE_OP  = 16'h0007;
   localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
   localparam logic [15:0] CW_HOME_START  = 16'h0010;

   typedef struct packed {
      logic [3:0] drive_state;
      logic [2:0] home_phase;
   } decode_type;

endpackage

`default_nettype wire

// File: hdl/dpcs_decode.sv
// Statusword decoder: drive state and homing state.
// Depends on dpcs_pkg.
`default_nettype none

module dpcs_decode (
   input  wire logic [15:0]          statusword,
   output dpcs_pkg::decode_type      decode
);

   logic [15:0] m6f;
   logic [15:0] m4f;
   logic [15:0] mh;

   assign m6f = statusword & dpcs_pkg::SW_MASK_6F;
   assign m4f = statusword & dpcs_pkg::SW_MASK_4F;
   assign mh  = statusword & dpcs_pkg::HOMING_MASK;

   always_comb begin
      priority if (m4f == 16'h0040) decode.drive_state = dpcs_pkg::DS_SO_DIS;
      else if (m6f == 16'h0021)     decode.drive_state = dpcs_pkg::DS_READY;
      else if (m6f == 16'h0023)     decode.drive_state = dpcs_pkg::DS_SWITCHED;
      else if (m6f == 16'h0027)     decode.drive_state = dpcs_pkg::DS_OP_EN;
      else if (m6f == 16'h0007)     decode.drive_state = dpcs_pkg::DS_QSTOP;
      else if (m4f == 16'h000F)     decode.drive_state = dpcs_pkg::DS_FR_ACTIVE;
      else if (m4f == 16'h0008)     decode.drive_state = dpcs_pkg::DS_FAULT;
      else if (m4f == 16'h0000)     decode.drive_state = dpcs_pkg::DS_NOT_READY;
      else                          decode.drive_state = dpcs_pkg::DS_UNKNOWN;

      unique case (mh)
         16'h0000: decode.home_phase = dpcs_pkg::HS_IN_PROGRESS;
         16'h0400: decode.home_phase = dpcs_pkg::HS_INTERRUPTED;
         16'h1000: decode.home_phase = dpcs_pkg::HS_NO_TARGET;
         16'h1400: decode.home_phase = dpcs_pkg::HS_FINISHED;
         16'h2000: decode.home_phase = dpcs_pkg::HS_ERR_VEL;
         16'h2400: decode.home_phase = dpcs_pkg::HS_ERROR;
         default:  decode.home_phase = dpcs_pkg::HS_UNKNOWN;
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/dpcs_step.sv
// Next controlword, mode and result status for one command.
// Depends on dpcs_pkg.
`default_nettype none

module dpcs_step (
   input  wire logic [1:0]           op,
   input  wire logic                 enable,
   input  wire logic signed [7:0]    mode_shown,
   input  wire logic signed [7:0]    mode_request,
   input  wire logic signed [7:0]    homing_mode_code,
   input  wire dpcs_pkg::decode_type decode,
   input  wire logic [15:0]          control_cur,
   input  wire logic signed [7:0]    mode_cur,
   output logic [15:0]               control_next,
   output logic signed [7:0]         mode_next,
   output logic [1:0]                status
);

   // Power-on sequencing toward operation enabled (enable high)
   logic [15:0] pw_ctl;
   logic [1:0]  pw_st;

   always_comb begin
      unique case (decode.drive_state)
         dpcs_pkg::DS_FAULT, dpcs_pkg::DS_FR_ACTIVE: begin
            pw_ctl = control_cur;
            pw_st  = dpcs_pkg::ST_ERROR;
         end
         dpcs_pkg::DS_SO_DIS: begin
            pw_ctl = dpcs_pkg::CW_SHUTDOWN;
            pw_st  = dpcs_pkg::ST_BUSY;
         end
         dpcs_pkg::DS_READY: begin
            pw_ctl = dpcs_pkg::CW_SWITCH_ON;
            pw_st  = dpcs_pkg::ST_BUSY;
         end
         dpcs_pkg::DS_SWITCHED: begin
            pw_ctl = dpcs_pkg::CW_ENABLE_OP;
            pw_st  = dpcs_pkg::ST_BUSY;
         end
         dpcs_pkg::DS_OP_EN: begin
            pw_ctl = dpcs_pkg::CW_ENABLE_OP;
            pw_st  = dpcs_pkg::ST_DONE;
         end
         dpcs_pkg::DS_QSTOP: begin
            pw_ctl = dpcs_pkg::CW_DISABLE_OP;
            pw_st  = dpcs_pkg::ST_BUSY;
         end
         default: begin
            pw_ctl = dpcs_pkg::CW_ZERO;
            pw_st  = dpcs_pkg::ST_BUSY;
         end
      endcase
   end

   logic [15:0] cur_no_start;
   assign cur_no_start = control_cur & ~dpcs_pkg::CW_HOME_START;

   always_comb begin
      control_next = control_cur;
      mode_next    = mode_cur;
      status       = dpcs_pkg::ST_DONE;
      unique case (op)
         dpcs_pkg::OP_POWER: begin
            if (enable) begin
               control_next = pw_ctl;
               status       = pw_st;
            end else begin
               control_next = dpcs_pkg::CW_DISABLE_OP;
               status = (decode.drive_state == dpcs_pkg::DS_OP_EN) ?
                        dpcs_pkg::ST_BUSY : dpcs_pkg::ST_DONE;
            end
         end
         dpcs_pkg::OP_HOMING: begin
            mode_next = homing_mode_code;
            priority if (!enable) begin
               control_next = cur_no_start;
               status       = dpcs_pkg::ST_DONE;
            end else if (decode.home_phase == dpcs_pkg::HS_ERR_VEL ||
                         decode.home_phase == dpcs_pkg::HS_ERROR) begin
               control_next = cur_no_start;
               status       = dpcs_pkg::ST_ERROR;
            end else if (decode.home_phase == dpcs_pkg::HS_FINISHED) begin
               control_next = dpcs_pkg::CW_ENABLE_OP & ~dpcs_pkg::CW_HOME_START;
               status       = dpcs_pkg::ST_DONE;
            end else if (mode_shown != homing_mode_code) begin
               control_next = cur_no_start;
               status       = dpcs_pkg::ST_BUSY;
            end else if (pw_st == dpcs_pkg::ST_ERROR) begin
               control_next = pw_ctl;
               status       = dpcs_pkg::ST_ERROR;
            end else if (pw_st == dpcs_pkg::ST_BUSY) begin
               control_next = pw_ctl & ~dpcs_pkg::CW_HOME_START;
               status       = dpcs_pkg::ST_BUSY;
            end else begin
               // drive is enabled: raise the start bit
               control_next = pw_ctl | dpcs_pkg::CW_HOME_START;
               status       = dpcs_pkg::ST_BUSY;
            end
         end
         dpcs_pkg::OP_CLEAR: begin
            if (decode.drive_state == dpcs_pkg::DS_FAULT) begin
               control_next = dpcs_pkg::CW_FAULT_RESET;
               status       = dpcs_pkg::ST_BUSY;
            end else begin
               control_next = dpcs_pkg::CW_ZERO;
               status = (decode.drive_state == dpcs_pkg::DS_FR_ACTIVE) ?
                        dpcs_pkg::ST_BUSY : dpcs_pkg::ST_DONE;
            end
         end
         default: begin
            mode_next = mode_request;
            status    = (mode_shown == mode_request) ?
                        dpcs_pkg::ST_DONE : dpcs_pkg::ST_BUSY;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/drive_profile_controlword_sequencer.sv
// Drive profile controlword sequencer, top level.
// Command beats enter on the req_ channel with the drive's statusword and
// displayed mode; each beat yields exactly one rsp_ beat carrying the new
// controlword, mode of operation, done/busy/error status and the decoded
// drive and homing states.
// Path: an accepted req_ beat is captured in the input register, then decoded
// and selected into the result register, which drives rsp_valid.
// Throughput: one beat per cycle while rsp_ready is high. The held controlword
// and mode are updated as a beat moves from the input register to the result
// register, so the next beat already sees them.
// Stall: while rsp_ready is low the result holds; one more beat can wait in
// the input register, after which req_ready drops.
// Reset: clears both stages, the controlword and mode to zero, and the homing
// mode code to HOMING_MODE_INIT (6 by default). csr_wr_en writes the homing mode code at once.
// Depends on dpcs_pkg, dpcs_decode and dpcs_step.
`default_nettype none

module drive_profile_controlword_sequencer #(
   parameter logic signed [7:0] HOMING_MODE_INIT = dpcs_pkg::HOMING_MODE_RESET
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic signed [7:0]   csr_wr_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_op,
   input  wire logic                req_enable,
   input  wire logic [15:0]         req_statusword,
   input  wire logic signed [7:0]   req_mode_shown,
   input  wire logic signed [7:0]   req_mode_request,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [15:0]              rsp_control_out,
   output logic signed [7:0]        rsp_mode_out,
   output logic [1:0]               rsp_result_status,
   output logic [3:0]               rsp_drive_state,
   output logic [2:0]               rsp_home_phase
);

   logic signed [7:0] homing_mode_ff;

   // input register
   logic              in_valid_ff;
   logic [1:0]        op_ff;
   logic              enable_ff;
   logic [15:0]       statusword_ff;
   logic signed [7:0] mode_shown_ff;
   logic signed [7:0] mode_request_ff;

   // held drive command state
   logic [15:0]       control_ff;
   logic signed [7:0] mode_ff;

   // result register
   logic              out_valid_ff;
   logic [15:0]       out_control_ff;
   logic signed [7:0] out_mode_ff;
   logic [1:0]        out_status_ff;
   logic [3:0]        out_drive_ff;
   logic [2:0]        out_homing_ff;

   dpcs_pkg::decode_type decode;
   logic [15:0]          control_in;
   logic signed [7:0]    mode_in;
   logic [1:0]           status_in;
   logic                 advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   dpcs_decode u_decode (
      .statusword (statusword_ff),
      .decode     (decode)
   );

   dpcs_step u_step (
      .op               (op_ff),
      .enable           (enable_ff),
      .mode_shown       (mode_shown_ff),
      .mode_request     (mode_request_ff),
      .homing_mode_code (homing_mode_ff),
      .decode           (decode),
      .control_cur      (control_ff),
      .mode_cur         (mode_ff),
      .control_next     (control_in),
      .mode_next        (mode_in),
      .status           (status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         homing_mode_ff <= HOMING_MODE_INIT;
      end else if (csr_wr_en) begin
         homing_mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff           <= req_op;
         enable_ff       <= req_enable;
         statusword_ff   <= req_statusword;
         mode_shown_ff   <= req_mode_shown;
         mode_request_ff <= req_mode_request;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= dpcs_pkg::CW_ZERO;
         mode_ff    <= '0;
      end else if (advance) begin
         control_ff <= control_in;
         mode_ff    <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_control_ff <= control_in;
         out_mode_ff    <= mode_in;
         out_status_ff  <= status_in;
         out_drive_ff   <= decode.drive_state;
         out_homing_ff  <= decode.home_phase;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_control_out   = out_control_ff;
   assign rsp_mode_out      = out_mode_ff;
   assign rsp_result_status = out_status_ff;
   assign rsp_drive_state   = out_drive_ff;
   assign rsp_home_phase    = out_homing_ff;

endmodule

`default_nettype wire

// File: hdl/dpcs_checker.sv
// Port-level checks for the drive profile controlword sequencer, bound to
// the top level. Depends on dpcs_pkg.
`default_nettype none

module dpcs_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [15:0]       rsp_control_out,
   input wire logic signed [7:0] rsp_mode_out,
   input wire logic [1:0]        rsp_result_status,
   input wire logic [3:0]        rsp_drive_state,
   input wire logic [2:0]        rsp_home_phase
);

   // no result beat right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_control_out) &&
      $stable(rsp_mode_out) && $stable(rsp_result_status) &&
      $stable(rsp_drive_state) && $stable(rsp_home_phase))
      else $error("stalled result beat changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_status <= dpcs_pkg::ST_ERROR)
      else $error("invalid result status");

   a_decode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive_state <= dpcs_pkg::DS_UNKNOWN &&
      rsp_home_phase <= dpcs_pkg::HS_UNKNOWN)
      else $error("decoded state out of range");

   // error only comes from a faulted drive or a homing error
   a_error_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_status == dpcs_pkg::ST_ERROR |->
      rsp_drive_state == dpcs_pkg::DS_FAULT ||
      rsp_drive_state == dpcs_pkg::DS_FR_ACTIVE ||
      rsp_home_phase == dpcs_pkg::HS_ERR_VEL ||
      rsp_home_phase == dpcs_pkg::HS_ERROR)
      else $error("error status without a fault or homing error");

endmodule

bind drive_profile_controlword_sequencer dpcs_checker u_dpcs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_control_out   (rsp_control_out),
   .rsp_mode_out      (rsp_mode_out),
   .rsp_result_status (rsp_result_status),
   .rsp_drive_state   (rsp_drive_state),
   .rsp_home_phase    (rsp_home_phase)
);

`default_nettype wire
